// ===== sv/mi3_pkg.sv =====
// mi3_pkg: shared types and index tables for the 3x3 matrix inverse pipeline.
// No dependencies.
`default_nettype none

package mi3_pkg;

  localparam int unsigned N_ENT = 9;  // matrix entries per item
  localparam int unsigned N_DET = 6;  // Sarrus terms
  localparam int unsigned N_PRD = 18; // cofactor partial products

  // Sarrus terms: entries x, y, z of x*y*z; the first three are added,
  // the last three subtracted.
  localparam int DET_IDX [N_DET][3] = '{
    '{0, 4, 8}, '{1, 5, 6}, '{2, 3, 7},
    '{2, 4, 6}, '{1, 3, 8}, '{0, 5, 7}
  };

  // Adjugate entry k = a[p]*a[q] - a[r]*a[s], row-major output order.
  localparam int COF_IDX [N_ENT][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // Sideband that travels with the reciprocal divider.
  typedef struct packed {
    logic vld;
    logic zero;
    logic neg;
  } mi3_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mi3_recip.sv =====
// mi3_recip: pipelined restoring divider giving the saturated, signed
// reciprocal 2^(2*FRAC_BITS)/det rounded half away from zero. Uses mi3_pkg.
`default_nettype none

module mi3_recip import mi3_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire mi3_ctl_t                      ctl_in,
  input  wire logic [ENTRY_WIDTH-1:0]        mag_in,
  output mi3_ctl_t                           ctl_out,
  output logic signed [ENTRY_WIDTH-1:0]      recip_out
);

  localparam int W  = ENTRY_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = ((2 * F > W - 1) ? 2 * F : W - 1) + 1;
  localparam logic [NW-1:0] ONE_NUM = NW'(1) << (2 * F);
  localparam logic [NW-1:0] LIM     = NW'(1) << (W - 1);

  // Per-step state: partial remainder, numerator bits left, quotient, divisor
  logic [W:0]     rem_r [NW+1];
  logic [NW-1:0]  num_r [NW+1];
  logic [NW-1:0]  q_r   [NW+1];
  logic [W-1:0]   d_r   [NW+1];
  mi3_ctl_t       ctl_r [NW+1];
  logic [NW-1:0]  num_nxt;

  assign num_nxt = ONE_NUM + NW'(mag_in >> 1);

  // Load step: numerator with the rounding half of the divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_in;
    end
    if (en) begin
      rem_r[0] <= '0;
      num_r[0] <= num_nxt;
      q_r[0]   <= '0;
      d_r[0]   <= mag_in;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [W:0] trial;
    logic       ge;
    assign trial = {rem_r[k][W-1:0], num_r[k][NW-1]};
    assign ge    = (trial >= {1'b0, d_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
      if (en) begin
        rem_r[k+1] <= ge ? (trial - {1'b0, d_r[k]}) : trial;
        num_r[k+1] <= {num_r[k][NW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][NW-2:0], ge};
        d_r[k+1]   <= d_r[k];
      end
    end
  end

  // Sign and saturate to the entry range
  logic signed [W-1:0] recip_nxt;
  logic [NW-1:0]       qf;
  assign qf = q_r[NW];

  always_comb begin
    if (!ctl_r[NW].neg) begin
      recip_nxt = (qf >= LIM) ? {1'b0, {(W-1){1'b1}}} : qf[W-1:0];
    end else begin
      recip_nxt = (qf >= LIM) ? {1'b1, {(W-1){1'b0}}} : -qf[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_r[NW];
    end
    if (en) begin
      recip_out <= recip_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/matrix_inverse_3x3.sv =====
// Inverse of a 3x3 signed fixed-point matrix (default Q16.16) by the adjugate.
// One matrix is accepted per cycle and one result leaves per cycle while the
// pipeline is not held. The bit-per-stage reciprocal divider works on
// NW = max(2*FRAC_BITS, ENTRY_WIDTH-1)+1 numerator bits (33 at defaults). The
// whole pipeline holds while out_valid is high and out_ready low. Every rounded
// product is round half up and saturated; a zero determinant gives singular=1
// and a zero matrix. Depends on mi3_pkg and mi3_recip.
`default_nettype none

module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a00,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a01,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a02,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a10,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a11,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a12,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a20,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a21,
  input  wire logic signed [ENTRY_WIDTH-1:0]  in_a22,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [ENTRY_WIDTH-1:0]       out_r00,
  output logic signed [ENTRY_WIDTH-1:0]       out_r01,
  output logic signed [ENTRY_WIDTH-1:0]       out_r02,
  output logic signed [ENTRY_WIDTH-1:0]       out_r10,
  output logic signed [ENTRY_WIDTH-1:0]       out_r11,
  output logic signed [ENTRY_WIDTH-1:0]       out_r12,
  output logic signed [ENTRY_WIDTH-1:0]       out_r20,
  output logic signed [ENTRY_WIDTH-1:0]       out_r21,
  output logic signed [ENTRY_WIDTH-1:0]       out_r22,
  output logic signed [ENTRY_WIDTH-1:0]       out_determinant,
  output logic                                out_singular
);

  localparam int W  = ENTRY_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = ((2 * F > W - 1) ? 2 * F : W - 1) + 1;
  localparam int DL = NW + 2; // depth of the delay line that matches the divider

  localparam logic signed [2*W:0] HALF = (2 * W + 1)'(1) << (F - 1);
  localparam logic signed [2*W:0] MAXW = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [2*W:0] MINW = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};
  localparam logic signed [W+2:0] MAXS = {4'b0000, {(W - 1){1'b1}}};
  localparam logic signed [W+2:0] MINS = {4'b1111, {(W - 1){1'b0}}};

  // Round half up, drop fraction bits, saturate to the entry range
  function automatic logic signed [W-1:0] rnd_sat(input logic signed [2*W:0] p);
    logic signed [2*W:0] s;
    s = (p + HALF) >>> F;
    if (s > MAXW) begin
      return {1'b0, {(W - 1){1'b1}}};
    end else if (s < MINW) begin
      return {1'b1, {(W - 1){1'b0}}};
    end
    return s[W-1:0];
  endfunction

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vm_r;

  // Whole pipeline advances unless the output register is stuck
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: input registers
  logic signed [W-1:0] a_r [N_ENT];
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= in_a00; a_r[1] <= in_a01; a_r[2] <= in_a02;
      a_r[3] <= in_a10; a_r[4] <= in_a11; a_r[5] <= in_a12;
      a_r[6] <= in_a20; a_r[7] <= in_a21; a_r[8] <= in_a22;
    end
  end

  // Stage 2: first products of Sarrus terms and cofactor products
  logic signed [2*W-1:0] pd_r [N_DET];
  logic signed [W-1:0]   z2_r [N_DET];
  logic signed [2*W-1:0] cp_r [N_PRD];
  for (genvar i = 0; i < N_DET; i++) begin : g_s2d
    always_ff @(posedge clk) begin
      if (en) begin
        pd_r[i] <= a_r[DET_IDX[i][0]] * a_r[DET_IDX[i][1]];
        z2_r[i] <= a_r[DET_IDX[i][2]];
      end
    end
  end
  for (genvar i = 0; i < N_ENT; i++) begin : g_s2c
    always_ff @(posedge clk) begin
      if (en) begin
        cp_r[2*i]   <= a_r[COF_IDX[i][0]] * a_r[COF_IDX[i][1]];
        cp_r[2*i+1] <= a_r[COF_IDX[i][2]] * a_r[COF_IDX[i][3]];
      end
    end
  end

  // Stage 3: round x*y; adjugate entries from exact differences
  logic signed [W-1:0] xy_r  [N_DET];
  logic signed [W-1:0] z3_r  [N_DET];
  logic signed [W-1:0] adj3_r [N_ENT];
  for (genvar i = 0; i < N_DET; i++) begin : g_s3d
    always_ff @(posedge clk) begin
      if (en) begin
        xy_r[i] <= rnd_sat((2 * W + 1)'(pd_r[i]));
        z3_r[i] <= z2_r[i];
      end
    end
  end
  for (genvar i = 0; i < N_ENT; i++) begin : g_s3c
    always_ff @(posedge clk) begin
      if (en) begin
        adj3_r[i] <= rnd_sat((2 * W + 1)'(cp_r[2*i]) - (2 * W + 1)'(cp_r[2*i+1]));
      end
    end
  end

  // Stage 4: second products of Sarrus terms
  logic signed [2*W-1:0] t_r    [N_DET];
  logic signed [W-1:0]   adj4_r [N_ENT];
  for (genvar i = 0; i < N_DET; i++) begin : g_s4
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[i] <= xy_r[i] * z3_r[i];
      end
    end
  end

  // Stage 5: round Sarrus terms
  logic signed [W-1:0] tr_r   [N_DET];
  logic signed [W-1:0] adj5_r [N_ENT];
  for (genvar i = 0; i < N_DET; i++) begin : g_s5
    always_ff @(posedge clk) begin
      if (en) begin
        tr_r[i] <= rnd_sat((2 * W + 1)'(t_r[i]));
      end
    end
  end

  // Stage 6: exact sum of the six terms, saturated
  logic signed [W+2:0] sum;
  logic signed [W-1:0] det6_r;
  logic signed [W-1:0] adj6_r [N_ENT];
  assign sum = (W + 3)'(tr_r[0]) + (W + 3)'(tr_r[1]) + (W + 3)'(tr_r[2])
             - (W + 3)'(tr_r[3]) - (W + 3)'(tr_r[4]) - (W + 3)'(tr_r[5]);
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > MAXS) begin
        det6_r <= {1'b0, {(W - 1){1'b1}}};
      end else if (sum < MINS) begin
        det6_r <= {1'b1, {(W - 1){1'b0}}};
      end else begin
        det6_r <= sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adj4_r <= adj3_r;
      adj5_r <= adj4_r;
      adj6_r <= adj5_r;
    end
  end

  // Reciprocal of the determinant
  mi3_ctl_t            dctl_in, dctl_out;
  logic [W-1:0]        mag;
  logic signed [W-1:0] recip;
  assign dctl_in.vld  = v6_r;
  assign dctl_in.zero = (det6_r == '0);
  assign dctl_in.neg  = det6_r[W-1];
  assign mag          = det6_r[W-1] ? -det6_r : det6_r;

  mi3_recip #(
    .FRAC_BITS   (FRAC_BITS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl_in    (dctl_in),
    .mag_in    (mag),
    .ctl_out   (dctl_out),
    .recip_out (recip)
  );

  // Delay line matching the divider for adjugate and determinant
  logic signed [W-1:0] adj_dl_r [DL][N_ENT];
  logic signed [W-1:0] det_dl_r [DL];
  always_ff @(posedge clk) begin
    if (en) begin
      adj_dl_r[0] <= adj6_r;
      det_dl_r[0] <= det6_r;
      for (int k = 1; k < DL; k++) begin
        adj_dl_r[k] <= adj_dl_r[k-1];
        det_dl_r[k] <= det_dl_r[k-1];
      end
    end
  end

  // Multiply stage: adjugate times reciprocal
  logic signed [2*W-1:0] pm_r [N_ENT];
  logic signed [W-1:0]   detm_r;
  logic                  zm_r;
  for (genvar i = 0; i < N_ENT; i++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        pm_r[i] <= adj_dl_r[DL-1][i] * recip;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      detm_r <= det_dl_r[DL-1];
      zm_r   <= dctl_out.zero;
    end
  end

  // Output register: round, saturate, force zero when singular
  logic signed [W-1:0] r_r [N_ENT];
  for (genvar i = 0; i < N_ENT; i++) begin : g_out
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i] <= zm_r ? '0 : rnd_sat((2 * W + 1)'(pm_r[i]));
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_determinant <= detm_r;
      out_singular    <= zm_r;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; vm_r <= 1'b0; out_valid <= 1'b0;
    end else if (en) begin
      v1_r      <= in_valid;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      vm_r      <= dctl_out.vld;
      out_valid <= vm_r;
    end
  end

  assign out_r00 = r_r[0]; assign out_r01 = r_r[1]; assign out_r02 = r_r[2];
  assign out_r10 = r_r[3]; assign out_r11 = r_r[4]; assign out_r12 = r_r[5];
  assign out_r20 = r_r[6]; assign out_r21 = r_r[7]; assign out_r22 = r_r[8];

endmodule

`default_nettype wire
